/* rtl/core/kernel_svm_pegasos_update_assert.svh */
// Assertion macros for the kernel Pegasos update block.
// Needs nothing else; included by the top level, which supplies clock and reset names.
`ifndef KERNEL_SVM_PEGASOS_UPDATE_ASSERT_SVH
`define KERNEL_SVM_PEGASOS_UPDATE_ASSERT_SVH

// same-cycle implication
`define KPEG_CHECK_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpeg assertion failed");

// next-cycle implication
`define KPEG_CHECK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpeg assertion failed");

`endif

/* rtl/core/kpeg_pkg.sv */
// Shared types and constants for the kernel Pegasos update block.
// No dependencies; imported by every module of the block.
package kpeg_pkg;

  localparam int LANES = 4;      // kernel values per chunk word
  localparam int KW    = 24;     // kernel value, signed Q8.16
  localparam int AW    = 20;     // alpha count
  localparam int CW    = 20;     // iteration count
  localparam int SCW   = 11;     // sample_count register
  localparam int LAMW  = 32;     // lambda, Q16.16
  localparam int THRW  = LAMW + CW;
  localparam int ACCW  = 56;     // row accumulator
  localparam int MAGW  = KW + AW + 1;  // |K| * alpha * 2
  localparam int LSUMW = MAGW + 3;     // signed sum of four lane terms
  localparam int SIW   = 10;     // sample index / column field width

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CHUNK = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_LAMBDA  = 2'd0;
  localparam logic [1:0] REG_SAMPLES = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam logic [AW-1:0] ALPHA_MAX = '1;

  typedef struct packed {
    logic            neg;
    logic [MAGW-1:0] mag;
  } lane_term_t;

  typedef struct packed {
    logic lane_re;
    logic smp_re;
    logic alpha_we;
    logic label_we;
    logic label_bit;
  } bank_ctl_t;

endpackage

/* rtl/core/kpeg_lane.sv */
// One multiply lane: |K| * alpha * 2 with the sign folded from K and the label.
// Depends on kpeg_pkg.
module kpeg_lane (
  input  logic                          clk,
  input  logic signed [kpeg_pkg::KW-1:0] kernel,
  input  logic [kpeg_pkg::AW-1:0]       alpha,
  input  logic                          label,
  input  logic                          in_use,
  output kpeg_pkg::lane_term_t          term
);
  import kpeg_pkg::*;

  logic [KW-1:0]    mag;
  logic [KW+AW-1:0] prod;

  always_comb begin
    // most negative value maps to 2^23, which still fits in KW bits unsigned
    mag  = kernel[KW-1] ? KW'(~kernel + 1'b1) : KW'(kernel);
    prod = (KW+AW)'(mag) * (KW+AW)'(alpha);
  end

  always_ff @(posedge clk) begin
    term.neg <= kernel[KW-1] ^ ~label;
    term.mag <= in_use ? {prod, 1'b0} : '0;
  end

endmodule

/* rtl/core/kpeg_merge.sv */
// Merge stage: signed sum of the lane terms, registered.
// Depends on kpeg_pkg.
module kpeg_merge (
  input  logic                              clk,
  input  kpeg_pkg::lane_term_t              terms [kpeg_pkg::LANES],
  output logic signed [kpeg_pkg::LSUMW-1:0] lane_sum
);
  import kpeg_pkg::*;

  logic signed [LSUMW-1:0] sum;

  always_comb begin
    sum = '0;
    for (int l = 0; l < LANES; l++) begin
      if (terms[l].neg) begin
        sum = sum - LSUMW'(terms[l].mag);
      end else begin
        sum = sum + LSUMW'(terms[l].mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_sum <= sum;
  end

endmodule

/* rtl/core/kpeg_bank.sv */
// One interleaved bank of the alpha and label stores (column j lives in bank j mod LANES).
// Depends on kpeg_pkg. Lane port and sample port read with registered data.
module kpeg_bank #(
  parameter  int ROWS = 256,
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                    clk,
  input  kpeg_pkg::bank_ctl_t     ctl,
  input  logic [RW-1:0]           lane_row,
  input  logic [RW-1:0]           smp_row,
  input  logic [RW-1:0]           alpha_wrow,
  input  logic [kpeg_pkg::AW-1:0] alpha_wdata,
  output logic [kpeg_pkg::AW-1:0] lane_alpha,
  output logic                    lane_label,
  output logic [kpeg_pkg::AW-1:0] smp_alpha,
  output logic                    smp_label
);
  import kpeg_pkg::*;

  logic [AW-1:0] alpha_mem [ROWS];
  logic          label_mem [ROWS];

  always_ff @(posedge clk) begin
    if (ctl.alpha_we) begin
      alpha_mem[alpha_wrow] <= alpha_wdata;
    end
    if (ctl.lane_re) begin
      lane_alpha <= alpha_mem[lane_row];
    end
    if (ctl.smp_re) begin
      smp_alpha <= alpha_mem[smp_row];
    end
  end

  // label writes share the sample address (loads come straight off the input word)
  always_ff @(posedge clk) begin
    if (ctl.label_we) begin
      label_mem[smp_row] <= ctl.label_bit;
    end
    if (ctl.lane_re) begin
      lane_label <= label_mem[lane_row];
    end
    if (ctl.smp_re) begin
      smp_label <= label_mem[smp_row];
    end
  end

endmodule

/* rtl/core/kernel_svm_pegasos_update.sv */
// Top level of the kernel Pegasos trainer: control sequencer, accumulator, margin test.
// Depends on kpeg_pkg, kpeg_bank, kpeg_lane, kpeg_merge and the assertion header.

// After reset the alpha store is swept to zero, one row of all four banks per cycle,
// with busy high; configuration writes are taken meanwhile. A word is taken when
// start is high and busy is low. A label load does not raise busy. An alpha read
// passes through the bank read and the result register before result_valid strobes.
// A kernel row chunk runs through bank read, lane multiply, lane merge and
// accumulate, and the next word can be taken once the accumulate is done. The final
// chunk of a row adds the margin test, after which its result strobes on result_valid,
// and the block is free again in that same cycle. The result is shown for exactly one
// cycle and cannot be held off. MAX_SAMPLES must be a power of two of at least eight.
`include "kernel_svm_pegasos_update_assert.svh"

module kernel_svm_pegasos_update #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [kpeg_pkg::SIW-1:0]        sample_index,
  input  logic                            label_bit,
  input  logic [kpeg_pkg::SIW-1:0]        column_base,
  input  logic signed [kpeg_pkg::KW-1:0]  kernel_lane0,
  input  logic signed [kpeg_pkg::KW-1:0]  kernel_lane1,
  input  logic signed [kpeg_pkg::KW-1:0]  kernel_lane2,
  input  logic signed [kpeg_pkg::KW-1:0]  kernel_lane3,
  input  logic                            chunk_last,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [kpeg_pkg::LAMW-1:0]       cfg_wdata,
  output logic                            result_valid,
  output logic [kpeg_pkg::SIW-1:0]        result_index,
  output logic [kpeg_pkg::AW-1:0]         alpha_value,
  output logic                            was_updated,
  output logic [kpeg_pkg::CW-1:0]         iteration_number,
  output logic                            limit_reached
);
  import kpeg_pkg::*;

  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int XW   = (IW > SCW) ? IW : SCW;
  localparam int ROWS = MAX_SAMPLES / LANES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BW   = $clog2(LANES);
  localparam logic [XW:0]   MAX_X   = (XW+1)'(MAX_SAMPLES);
  localparam logic [RW-1:0] ROW_END = RW'(ROWS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;

  // control and configuration
  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [RW-1:0]   clr_row;
  logic [LAMW-1:0] lambda_scaled;
  logic [SCW-1:0]  sample_count;
  logic [CW-1:0]   iteration_limit;
  logic [CW-1:0]   iteration_count;
  logic [ACCW-1:0] row_acc;

  logic accept;

  // word decode
  logic signed [KW-1:0] kin [LANES];
  logic [XW-1:0]  idx_x;
  logic [IW-1:0]  idx_m;
  logic [BW-1:0]  idx_bank;
  logic [RW-1:0]  idx_row;
  logic [XW-1:0]  jx       [LANES];
  logic [IW-1:0]  jm       [LANES];
  logic [BW-1:0]  jbank    [LANES];
  logic [RW-1:0]  jrow     [LANES];
  logic           lane_ok  [LANES];
  logic [RW-1:0]  bank_row [LANES];

  // per-word registers
  logic signed [KW-1:0] k_reg [LANES];
  logic           lane_ok_reg   [LANES];
  logic [BW-1:0]  lane_bank_reg [LANES];
  logic           last_reg;
  logic [BW-1:0]  idx_bank_reg;
  logic [RW-1:0]  idx_row_reg;
  logic [SIW-1:0] ridx_reg;

  // bank side
  bank_ctl_t      bank_ctl     [LANES];
  logic [AW-1:0]  lane_alpha_b [LANES];
  logic           lane_label_b [LANES];
  logic [AW-1:0]  smp_alpha_b  [LANES];
  logic           smp_label_b  [LANES];
  logic [RW-1:0]  alpha_wrow;
  logic [AW-1:0]  alpha_wdata;

  lane_term_t              terms [LANES];
  logic signed [LSUMW-1:0] lane_sum;

  // margin test
  logic [CW-1:0]   count_plus;
  logic [THRW-1:0] thr;
  logic [AW-1:0]   smp_alpha;
  logic            smp_label;
  logic [AW-1:0]   alpha_inc;
  logic [ACCW-1:0] signed_sum;
  logic            less;
  logic            at_limit;
  logic            upd;
  logic            clearing;
  logic            cmp_write;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign kin[0] = kernel_lane0;
  assign kin[1] = kernel_lane1;
  assign kin[2] = kernel_lane2;
  assign kin[3] = kernel_lane3;

  always_comb begin
    idx_x    = XW'(sample_index);
    idx_m    = idx_x[IW-1:0];
    idx_bank = BW'(idx_m % LANES);
    idx_row  = RW'(idx_m / LANES);
    for (int l = 0; l < LANES; l++) begin
      jx[l]      = XW'(column_base) + XW'(l);
      jm[l]      = jx[l][IW-1:0];
      jbank[l]   = BW'(jm[l] % LANES);
      jrow[l]    = RW'(jm[l] / LANES);
      lane_ok[l] = ({1'b0, jx[l]} < MAX_X) && ({1'b0, jx[l]} < (XW+1)'(sample_count));
    end
  end

  // route each lane's row address to the bank holding its column
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_row[b] = '0;
      for (int l = 0; l < LANES; l++) begin
        if (jbank[l] == BW'(b)) begin
          bank_row[b] = jrow[l];
        end
      end
    end
  end

  assign clearing    = (state == ST_CLEAR);
  assign cmp_write   = (state == ST_CMP) && upd;
  assign alpha_wrow  = clearing ? clr_row : idx_row_reg;
  assign alpha_wdata = clearing ? '0 : alpha_inc;

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_ctl[b].lane_re   = accept && (action == ACT_CHUNK);
      bank_ctl[b].smp_re    = accept && ((action == ACT_CHUNK) || (action == ACT_READ));
      bank_ctl[b].alpha_we  = clearing || (cmp_write && (idx_bank_reg == BW'(b)));
      bank_ctl[b].label_we  = accept && (action == ACT_LOAD) && (idx_bank == BW'(b));
      bank_ctl[b].label_bit = label_bit;
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    kpeg_bank #(
      .ROWS(ROWS)
    ) u_bank (
      .clk        (clk),
      .ctl        (bank_ctl[b]),
      .lane_row   (bank_row[b]),
      .smp_row    (idx_row),
      .alpha_wrow (alpha_wrow),
      .alpha_wdata(alpha_wdata),
      .lane_alpha (lane_alpha_b[b]),
      .lane_label (lane_label_b[b]),
      .smp_alpha  (smp_alpha_b[b]),
      .smp_label  (smp_label_b[b])
    );
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    kpeg_lane u_lane (
      .clk   (clk),
      .kernel(k_reg[l]),
      .alpha (lane_alpha_b[lane_bank_reg[l]]),
      .label (lane_label_b[lane_bank_reg[l]]),
      .in_use(lane_ok_reg[l]),
      .term  (terms[l])
    );
  end

  kpeg_merge u_merge (
    .clk     (clk),
    .terms   (terms),
    .lane_sum(lane_sum)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int l = 0; l < LANES; l++) begin
        k_reg[l]         <= kin[l];
        lane_ok_reg[l]   <= lane_ok[l];
        lane_bank_reg[l] <= jbank[l];
      end
      last_reg     <= chunk_last;
      idx_bank_reg <= idx_bank;
      idx_row_reg  <= idx_row;
      ridx_reg     <= SIW'(idx_m);
    end
    if (state == ST_MUL) begin
      thr <= THRW'(lambda_scaled) * THRW'(count_plus);
    end
  end

  always_comb begin
    smp_alpha  = smp_alpha_b[idx_bank_reg];
    smp_label  = smp_label_b[idx_bank_reg];
    count_plus = iteration_count + 1'b1;
    alpha_inc  = (smp_alpha != ALPHA_MAX) ? smp_alpha + 1'b1 : smp_alpha;
    // label -1 flips the sign of the row sum
    signed_sum = smp_label ? row_acc : ACCW'(ACCW'(0) - row_acc);
    less       = signed_sum[ACCW-1] || (signed_sum < ACCW'(thr));
    at_limit   = (iteration_count >= iteration_limit);
    upd        = !at_limit && less;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_END) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (action == ACT_CHUNK)) state_next = ST_MUL;
        else if (accept && (action == ACT_READ)) state_next = ST_READ;
      end
      ST_MUL:   state_next = ST_MERGE;
      ST_MERGE: state_next = ST_ACC;
      ST_ACC:   state_next = last_reg ? ST_CMP : ST_IDLE;
      ST_CMP:   state_next = ST_IDLE;
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_row         <= '0;
      row_acc         <= '0;
      iteration_count <= '0;
      result_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_CMP) || (state == ST_READ);
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
      end
      if (state == ST_ACC) begin
        row_acc <= row_acc + ACCW'(lane_sum);
      end else if (state == ST_CMP) begin
        row_acc <= '0;
      end
      if ((state == ST_CMP) && !at_limit) begin
        iteration_count <= count_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_scaled   <= LAMW'(65536);
      sample_count    <= SCW'(1024);
      iteration_limit <= CW'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAMBDA:  lambda_scaled   <= cfg_wdata;
        REG_SAMPLES: sample_count    <= cfg_wdata[SCW-1:0];
        REG_LIMIT:   iteration_limit <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      result_index     <= ridx_reg;
      alpha_value      <= upd ? alpha_inc : smp_alpha;
      was_updated      <= upd;
      iteration_number <= at_limit ? iteration_count : count_plus;
      limit_reached    <= at_limit;
    end else if (state == ST_READ) begin
      result_index     <= ridx_reg;
      alpha_value      <= smp_alpha;
      was_updated      <= 1'b0;
      iteration_number <= iteration_count;
      limit_reached    <= 1'b0;
    end
  end

  `KPEG_CHECK_IMP(a_result_when_idle, clk, rst, result_valid, state == ST_IDLE)
  `KPEG_CHECK_IMP(a_update_not_limited, clk, rst, result_valid && was_updated, !limit_reached)
  `KPEG_CHECK_NEXT(a_chunk_enters_mul, clk, rst, accept && (action == ACT_CHUNK), state == ST_MUL)
  `KPEG_CHECK_NEXT(a_row_cleared, clk, rst, state == ST_CMP, row_acc == '0)

endmodule
